// ===== hdl/sqb_pkg.sv =====
`default_nettype none
package sqb_pkg;

  localparam logic [1:0] CMD_BEGIN = 2'd0;
  localparam logic [1:0] CMD_DRAW  = 2'd1;
  localparam logic [1:0] CMD_END   = 2'd2;

  localparam logic KIND_VERTEX = 1'b0;
  localparam logic KIND_FLUSH  = 1'b1;

  localparam logic [31:0] ONE_Q16     = 32'h0001_0000;
  localparam logic [63:0] Q30_ONE     = 64'h0000_0000_4000_0000;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] size_x;
    logic signed [31:0] size_y;
    logic [15:0]        angle;
    logic               textured;
    logic [31:0]        texture_id;
    logic [31:0]        tiling;
    logic [31:0]        color;
  } in_t;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] vert_x;
    logic signed [31:0] vert_y;
    logic signed [31:0] vert_z;
    logic [31:0]        vert_color;
    logic [1:0]         corner;
    logic [4:0]         tex_slot;
    logic [31:0]        vert_tiling;
    logic [12:0]        batch_indices;
    logic [5:0]         batch_slots;
    logic               last;
  } out_t;

  typedef struct packed {
    logic capture;
    logic emit_end;
    logic srch_step;
    logic srch_hit;
    logic trig;
    logic mul1;
    logic mul2;
    logic emit_flush;
    logic alloc;
    logic emit_vtx;
  } ctl_cmd_t;

  typedef struct packed {
    logic [1:0] in_cmd;
    logic       in_textured;
    logic       slot_single;
    logic       match;
    logic       srch_last;
    logic       need_flush;
    logic       out_free;
    logic       corner_last;
  } ctl_sts_t;

  // sine over a quarter turn, r in q30, result q16.16 in 0..65536
  function automatic logic [16:0] quarter_sine(logic [63:0] r);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] v;
    logic [63:0] s;
    if (r == 64'd0) return 17'd0;
    if (r >= Q30_ONE) return 17'd65536;
    x  = (r * HALF_PI_Q30) >> 30;
    x2 = (x * x) >> 30;
    v  = Q30_ONE;
    v  = Q30_ONE - ((x2 * v) >> 30) / 64'd156;
    v  = Q30_ONE - ((x2 * v) >> 30) / 64'd110;
    v  = Q30_ONE - ((x2 * v) >> 30) / 64'd72;
    v  = Q30_ONE - ((x2 * v) >> 30) / 64'd42;
    v  = Q30_ONE - ((x2 * v) >> 30) / 64'd20;
    v  = Q30_ONE - ((x2 * v) >> 30) / 64'd6;
    s  = (x * v) >> 30;
    s  = (s + 64'd8192) >> 14;
    if (s > 64'd65536) s = 64'd65536;
    return 17'(s);
  endfunction

  // sine of a q32 turn fraction, q16.16
  function automatic logic signed [17:0] turn_sine(logic [31:0] t);
    logic [63:0]        r;
    logic signed [17:0] v;
    r = {34'd0, t[29:0]};
    if (t[30]) v = $signed({1'b0, quarter_sine(Q30_ONE - r)});
    else       v = $signed({1'b0, quarter_sine(r)});
    return t[31] ? -v : v;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/sqb_ram.sv =====
`default_nettype none
module sqb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== hdl/sqb_ctrl.sv =====
`default_nettype none
module sqb_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire sqb_pkg::ctl_sts_t sts_i,
  output sqb_pkg::ctl_cmd_t      cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_END   = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_CMP   = 4'd3;
  localparam logic [3:0] S_TRIG  = 4'd4;
  localparam logic [3:0] S_MUL1  = 4'd5;
  localparam logic [3:0] S_MUL2  = 4'd6;
  localparam logic [3:0] S_DEC   = 4'd7;
  localparam logic [3:0] S_FLUSH = 4'd8;
  localparam logic [3:0] S_ALLOC = 4'd9;
  localparam logic [3:0] S_VTX   = 4'd10;

  logic [3:0] state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          case (sts_i.in_cmd)
            sqb_pkg::CMD_END: state_d = S_END;
            sqb_pkg::CMD_DRAW: begin
              if (sts_i.in_textured && !sts_i.slot_single) state_d = S_RD;
              else state_d = S_TRIG;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_END: begin
        if (sts_i.out_free) begin
          cmd_o.emit_end = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_RD: state_d = S_CMP;
      S_CMP: begin
        if (sts_i.match) begin
          cmd_o.srch_hit = 1'b1;
          state_d = S_TRIG;
        end else if (sts_i.srch_last) begin
          state_d = S_TRIG;
        end else begin
          cmd_o.srch_step = 1'b1;
          state_d = S_RD;
        end
      end
      S_TRIG: begin
        cmd_o.trig = 1'b1;
        state_d = S_MUL1;
      end
      S_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d = S_MUL2;
      end
      S_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d = S_DEC;
      end
      S_DEC: begin
        state_d = sts_i.need_flush ? S_FLUSH : S_ALLOC;
      end
      S_FLUSH: begin
        if (sts_i.out_free) begin
          cmd_o.emit_flush = 1'b1;
          state_d = S_ALLOC;
        end
      end
      S_ALLOC: begin
        cmd_o.alloc = 1'b1;
        state_d = S_VTX;
      end
      S_VTX: begin
        if (sts_i.out_free) begin
          cmd_o.emit_vtx = 1'b1;
          if (sts_i.corner_last) state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit_end || cmd_o.emit_flush || cmd_o.emit_vtx) |-> sts_i.out_free)
    else $error("result issued while output register busy");

  a_emit_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.emit_end, cmd_o.emit_flush, cmd_o.emit_vtx}))
    else $error("two results issued in one cycle");

  a_vtx_after_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.alloc |=> (state_q == S_VTX))
    else $error("vertex phase not entered after slot allocation");

endmodule
`default_nettype wire

// ===== hdl/sqb_dp.sv =====
`default_nettype none
module sqb_dp #(
  parameter int MAX_QUADS        = 1024,
  parameter int TEXTURE_SLOTS    = 32,
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire sqb_pkg::in_t      in_data_i,
  input  wire sqb_pkg::ctl_cmd_t cmd_i,
  output sqb_pkg::ctl_sts_t      sts_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output sqb_pkg::out_t          out_data_o
);

  localparam int QW = $clog2(MAX_QUADS + 1);
  localparam int CW = $clog2(TEXTURE_SLOTS + 1);
  localparam int SW = $clog2(TEXTURE_SLOTS);
  localparam int IW = $clog2(SINE_TABLE_DEPTH);
  localparam int AW = 17 + IW;

  // sine and cosine tables, q16.16
  logic signed [17:0] sin_rom [SINE_TABLE_DEPTH];
  logic signed [17:0] cos_rom [SINE_TABLE_DEPTH];

  for (genvar g = 0; g < SINE_TABLE_DEPTH; g++) begin : g_tab
    localparam logic [31:0] T = 32'((64'(g) << 32) / SINE_TABLE_DEPTH);
    assign sin_rom[g] = sqb_pkg::turn_sine(T);
    assign cos_rom[g] = sqb_pkg::turn_sine(T + 32'h4000_0000);
  end

  sqb_pkg::in_t       in_q;
  logic [QW-1:0]      qc_q;
  logic [CW-1:0]      sc_q;
  logic [SW-1:0]      srch_q;
  logic               found_q;
  logic [SW-1:0]      slot_q;
  logic [IW-1:0]      idx_q;
  logic signed [17:0] c_q, s_q;
  logic signed [49:0] p1_q, p2_q, p3_q, p4_q;
  logic [1:0]         corner_q;
  sqb_pkg::out_t      out_q, out_d;
  logic               out_valid_q;

  logic [AW-1:0]      aprod;
  logic               ram_we;
  logic [31:0]        ram_rdata;
  logic               xneg, yneg;
  logic signed [50:0] ax, ay;
  logic signed [51:0] rx, ry;
  logic [QW+2:0]      q6;
  logic               out_free;
  logic               out_load;

  assign aprod = AW'(in_data_i.angle) * AW'(SINE_TABLE_DEPTH);

  assign ram_we = cmd_i.alloc && in_q.textured && !found_q;

  sqb_ram #(
    .WIDTH(32),
    .DEPTH(TEXTURE_SLOTS)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(sc_q[SW-1:0]),
    .wdata_i(in_q.texture_id),
    .raddr_i(srch_q),
    .rdata_o(ram_rdata)
  );

  // corner sign pattern: x negative on 0 and 3, y negative on 0 and 1
  assign xneg = (corner_q == 2'd0) || (corner_q == 2'd3);
  assign yneg = !corner_q[1];

  assign ax = (xneg ? -51'(p1_q) : 51'(p1_q)) - (yneg ? -51'(p2_q) : 51'(p2_q));
  assign ay = (xneg ? -51'(p3_q) : 51'(p3_q)) + (yneg ? -51'(p4_q) : 51'(p4_q));
  assign rx = 52'(ax) + 52'sd65536;
  assign ry = 52'(ay) + 52'sd65536;

  assign q6 = (QW+3)'({qc_q, 2'b00}) + (QW+3)'({qc_q, 1'b0});

  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = cmd_i.emit_end || cmd_i.emit_flush || cmd_i.emit_vtx;

  always_comb begin
    sts_o             = '0;
    sts_o.in_cmd      = in_data_i.command;
    sts_o.in_textured = in_data_i.textured;
    sts_o.slot_single = (sc_q == CW'(1));
    sts_o.match       = (ram_rdata == in_q.texture_id);
    sts_o.srch_last   = ((CW'(srch_q) + CW'(1)) >= sc_q);
    sts_o.need_flush  = (qc_q >= QW'(MAX_QUADS)) ||
                        (in_q.textured && !found_q && (sc_q >= CW'(TEXTURE_SLOTS)));
    sts_o.out_free    = out_free;
    sts_o.corner_last = (corner_q == 2'd3);
  end

  // batch counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qc_q    <= '0;
      sc_q    <= CW'(1);
      found_q <= 1'b0;
    end else begin
      if (cmd_i.capture) begin
        found_q <= 1'b0;
        if (in_data_i.command == sqb_pkg::CMD_BEGIN) begin
          qc_q <= '0;
          sc_q <= CW'(1);
        end
      end
      if (cmd_i.srch_hit) found_q <= 1'b1;
      if (cmd_i.emit_flush) begin
        qc_q    <= '0;
        sc_q    <= CW'(1);
        found_q <= 1'b0;
      end
      if (ram_we) sc_q <= sc_q + CW'(1);
      if (cmd_i.emit_vtx && corner_q == 2'd3) qc_q <= qc_q + QW'(1);
    end
  end

  // item datapath
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      in_q   <= in_data_i;
      srch_q <= SW'(1);
      idx_q  <= aprod[16 +: IW];
    end
    if (cmd_i.srch_step) srch_q <= srch_q + SW'(1);
    if (cmd_i.srch_hit) slot_q <= srch_q;
    if (cmd_i.trig) begin
      c_q <= cos_rom[idx_q];
      s_q <= sin_rom[idx_q];
    end
    if (cmd_i.mul1) begin
      p1_q <= c_q * $signed(in_q.size_x);
      p2_q <= s_q * $signed(in_q.size_y);
    end
    if (cmd_i.mul2) begin
      p3_q <= s_q * $signed(in_q.size_x);
      p4_q <= c_q * $signed(in_q.size_y);
    end
    if (cmd_i.alloc) begin
      corner_q <= 2'd0;
      if (!in_q.textured) slot_q <= '0;
      else if (!found_q) slot_q <= sc_q[SW-1:0];
    end
    if (cmd_i.emit_vtx) corner_q <= corner_q + 2'd1;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_comb begin
    out_d = '0;
    if (cmd_i.emit_end || cmd_i.emit_flush) begin
      out_d.kind          = sqb_pkg::KIND_FLUSH;
      out_d.batch_indices = 13'(q6);
      out_d.batch_slots   = 6'(sc_q);
      out_d.last          = cmd_i.emit_end;
    end else begin
      out_d.kind          = sqb_pkg::KIND_VERTEX;
      out_d.vert_x        = in_q.pos_x + $signed(32'(rx >>> 17));
      out_d.vert_y        = in_q.pos_y + $signed(32'(ry >>> 17));
      out_d.vert_z        = in_q.pos_z;
      out_d.vert_color    = in_q.color;
      out_d.corner        = corner_q;
      out_d.tex_slot      = 5'(slot_q);
      out_d.vert_tiling   = in_q.textured ? in_q.tiling : sqb_pkg::ONE_Q16;
      out_d.last          = (corner_q == 2'd3);
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sc_q >= CW'(1)) && (sc_q <= CW'(TEXTURE_SLOTS)))
    else $error("slot count out of range");

  a_alloc_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (sc_q < CW'(TEXTURE_SLOTS)))
    else $error("slot appended to a full table");

  a_quad_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qc_q <= QW'(MAX_QUADS))
    else $error("quad count past batch size");

endmodule
`default_nettype wire

// ===== hdl/sprite_quad_batch_setup.sv =====
// channel   direction  signals                                 payload
// request   in         in_valid_i, in_stall_o, in_data_i       sqb_pkg::in_t
// result    out        out_valid_o, out_stall_i, out_data_o    sqb_pkg::out_t
//
// a draw passes the trig, mul1, mul2, decide, alloc and vertex states, with a
// slot table search first for a textured quad and a forced flush if needed;
// the search reads, then compares, each entry of a registered-read ram.
// reset clears the batch to empty with only the white slot bound.
// a stalled output register holds the controller in place until it drains.
`default_nettype none
module sprite_quad_batch_setup #(
  parameter int MAX_QUADS        = 1024,
  parameter int TEXTURE_SLOTS    = 32,
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  input  wire sqb_pkg::in_t in_data_i,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output sqb_pkg::out_t     out_data_o
);

  sqb_pkg::ctl_cmd_t cmd;
  sqb_pkg::ctl_sts_t sts;

  sqb_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  sqb_dp #(
    .MAX_QUADS       (MAX_QUADS),
    .TEXTURE_SLOTS   (TEXTURE_SLOTS),
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule
`default_nettype wire

// ===== test/sprite_quad_batch_setup_check.sv =====
`timescale 1ns / 100ps
`default_nettype none
module sprite_quad_batch_setup_check (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          in_stall_i,
  input  wire sqb_pkg::in_t  in_data_i,
  input  wire logic          out_valid_i,
  input  wire logic          out_stall_i,
  input  wire sqb_pkg::out_t out_data_i,
  output int                 errors_o,
  output int                 pending_o
);

  localparam int MaxQuads   = 1024;
  localparam int TexSlots   = 32;
  localparam int TableDepth = 1024;

  logic signed [63:0] sine_lut [TableDepth];
  logic signed [63:0] cosine_lut [TableDepth];
  logic [31:0]        bound_tex [TexSlots];
  int unsigned        quads_held;
  int unsigned        slots_bound;
  sqb_pkg::out_t      vertex_q [$];

  // quarter-wave sine, r in q30, q16.16 out
  function automatic logic [63:0] quarter_wave(logic [63:0] r);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] v;
    logic [63:0] s;
    logic [63:0] divs [6];
    divs = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
    if (r == 0) return 0;
    if (r >= 64'h4000_0000) return 65536;
    x  = (r * 64'd1686629713) >> 30;
    x2 = (x * x) >> 30;
    v  = 64'h4000_0000;
    for (int k = 0; k < 6; k++) v = 64'h4000_0000 - ((x2 * v) >> 30) / divs[k];
    s = ((((x * v) >> 30) + 64'd8192) >> 14);
    return (s > 65536) ? 64'd65536 : s;
  endfunction

  function automatic logic signed [63:0] wave(logic [31:0] t);
    logic [63:0] r;
    logic signed [63:0] v;
    r = {34'd0, t[29:0]};
    v = t[30] ? $signed(quarter_wave(64'h4000_0000 - r)) : $signed(quarter_wave(r));
    return t[31] ? -v : v;
  endfunction

  initial begin
    for (int i = 0; i < TableDepth; i++) begin
      sine_lut[i]   = wave(32'(i) << 22);
      cosine_lut[i] = wave((32'(i) << 22) + 32'h4000_0000);
    end
  end

  function automatic sqb_pkg::out_t flush_item(logic is_last);
    sqb_pkg::out_t f;
    f = '0;
    f.kind          = sqb_pkg::KIND_FLUSH;
    f.batch_indices = 13'(quads_held * 6);
    f.batch_slots   = 6'(slots_bound);
    f.last          = is_last;
    return f;
  endfunction

  task automatic predict_quad(sqb_pkg::in_t d);
    logic               hit;
    int unsigned        slot;
    logic [31:0]        tile;
    int unsigned        idx;
    logic signed [63:0] c, s, hx, hy, ax, ay;
    sqb_pkg::out_t      v;
    hit  = 1'b0;
    slot = 0;
    if (d.textured) begin
      for (int i = 1; i < slots_bound; i++) begin
        if (!hit && bound_tex[i] == d.texture_id) begin
          hit  = 1'b1;
          slot = i;
        end
      end
    end
    if (quads_held >= MaxQuads || (d.textured && !hit && slots_bound >= TexSlots)) begin
      vertex_q.push_back(flush_item(1'b0));
      quads_held  = 0;
      slots_bound = 1;
      hit         = 1'b0;
    end
    if (d.textured) begin
      if (!hit) begin
        slot = slots_bound;
        bound_tex[slot] = d.texture_id;
        slots_bound++;
      end
      tile = d.tiling;
    end else begin
      slot = 0;
      tile = sqb_pkg::ONE_Q16;
    end
    idx = d.angle >> 6;
    c   = cosine_lut[idx];
    s   = sine_lut[idx];
    for (int k = 0; k < 4; k++) begin
      hx = (k == 0 || k == 3) ? -64'(d.size_x) : 64'(d.size_x);
      hy = (k < 2) ? -64'(d.size_y) : 64'(d.size_y);
      ax = c * hx - s * hy;
      ay = s * hx + c * hy;
      v = '0;
      v.kind        = sqb_pkg::KIND_VERTEX;
      v.vert_x      = 32'(64'(d.pos_x) + ((ax + 65536) >>> 17));
      v.vert_y      = 32'(64'(d.pos_y) + ((ay + 65536) >>> 17));
      v.vert_z      = d.pos_z;
      v.vert_color  = d.color;
      v.corner      = 2'(k);
      v.tex_slot    = 5'(slot);
      v.vert_tiling = tile;
      v.last        = (k == 3);
      vertex_q.push_back(v);
    end
    quads_held++;
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      errors_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quads_held  = 0;
      slots_bound = 1;
      errors_o    = 0;
      vertex_q.delete();
    end else begin
      if (in_valid_i && !in_stall_i) begin
        case (in_data_i.command)
          sqb_pkg::CMD_BEGIN: begin
            quads_held  = 0;
            slots_bound = 1;
          end
          sqb_pkg::CMD_END:  vertex_q.push_back(flush_item(1'b1));
          sqb_pkg::CMD_DRAW: predict_quad(in_data_i);
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (vertex_q.size() == 0) begin
          $error("result with nothing expected: %h", out_data_i);
          errors_o++;
        end else begin
          sqb_pkg::out_t e;
          e = vertex_q.pop_front();
          check_field("kind", e.kind, out_data_i.kind);
          check_field("vert_x", e.vert_x, out_data_i.vert_x);
          check_field("vert_y", e.vert_y, out_data_i.vert_y);
          check_field("vert_z", e.vert_z, out_data_i.vert_z);
          check_field("vert_color", e.vert_color, out_data_i.vert_color);
          check_field("corner", e.corner, out_data_i.corner);
          check_field("tex_slot", e.tex_slot, out_data_i.tex_slot);
          check_field("vert_tiling", e.vert_tiling, out_data_i.vert_tiling);
          check_field("batch_indices", e.batch_indices, out_data_i.batch_indices);
          check_field("batch_slots", e.batch_slots, out_data_i.batch_slots);
          check_field("last", e.last, out_data_i.last);
        end
      end
    end
    pending_o = vertex_q.size();
  end

endmodule
`default_nettype wire

// ===== test/sprite_quad_batch_setup_test.sv =====
`timescale 1ns / 100ps
`default_nettype none
module sprite_quad_batch_setup_test;

  // command code the block ignores
  localparam logic [1:0] CmdUnused = 2'd3;

  logic          clk_i;
  logic          rst_ni;
  logic          in_valid_i;
  logic          in_stall_o;
  sqb_pkg::in_t  in_data_i;
  logic          out_valid_o;
  logic          out_stall_i;
  sqb_pkg::out_t out_data_o;
  int   errors;
  int   pending;
  logic quiet;
  int   stall_left;
  logic [31:0] id_pool [6];

  sprite_quad_batch_setup i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o
  );

  sprite_quad_batch_setup_check i_check (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_data_i(out_data_o),
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("sprite_quad_batch_setup_test failed");
    $finish;
  end

  // result side backpressure in bursts
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else if (quiet) begin
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      out_stall_i <= ($urandom_range(0, 2) == 0);
      stall_left  <= $urandom_range(1, 11);
    end
  end

  task automatic send(sqb_pkg::in_t d);
    logic taken;
    in_valid_i <= 1'b1;
    in_data_i  <= d;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
  endtask

  function automatic sqb_pkg::in_t mk_cmd(logic [1:0] cmd);
    sqb_pkg::in_t d;
    logic [319:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom};
    d = raw[$bits(sqb_pkg::in_t)-1:0];
    d.command = cmd;
    return d;
  endfunction

  function automatic sqb_pkg::in_t mk_draw(logic tex, logic [31:0] id);
    sqb_pkg::in_t d;
    d = mk_cmd(sqb_pkg::CMD_DRAW);
    d.textured   = tex;
    d.texture_id = id;
    if ($urandom_range(0, 2) != 0) begin
      d.size_x = $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
      d.size_y = $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
      d.pos_x  = $signed($urandom_range(0, 32'h1000_0000)) - 32'sh0800_0000;
    end
    return d;
  endfunction

  task automatic draw_at(logic [15:0] ang, logic [31:0] p, logic [31:0] sz);
    sqb_pkg::in_t d;
    d = mk_draw(1'b0, 32'd0);
    d.angle  = ang;
    d.pos_x  = p;
    d.pos_y  = ~p;
    d.size_x = sz;
    d.size_y = sz;
    send(d);
  endtask

  task automatic pick_draw();
    if ($urandom_range(0, 2) == 0) send(mk_draw(1'b0, $urandom));
    else if ($urandom_range(0, 3) == 0) send(mk_draw(1'b1, $urandom));
    else send(mk_draw(1'b1, id_pool[$urandom_range(0, 5)]));
  endtask

  initial begin
    in_valid_i = 1'b0;
    in_data_i  = '0;
    quiet      = 1'b0;
    rst_ni     = 1'b0;
    for (int i = 0; i < 6; i++) id_pool[i] = $urandom;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, every angle quadrant, slot reuse, odd commands
    send(mk_cmd(sqb_pkg::CMD_BEGIN));
    draw_at(16'd0, 32'h7fff_ffff, 32'h7fff_ffff);
    draw_at(16'd0, 32'h8000_0000, 32'h8000_0000);
    draw_at(16'd16384, 32'h0001_0000, 32'h0002_0000);
    draw_at(16'd32768, 32'h0, 32'hffff_0000);
    draw_at(16'd49152, 32'h0, 32'h0003_8000);
    draw_at(16'hffff, 32'h7fff_ffff, 32'h8000_0000);
    draw_at(16'd8192, 32'h0, 32'h0);
    send(mk_draw(1'b1, 32'hffff_ffff));
    send(mk_draw(1'b1, 32'h0));
    send(mk_draw(1'b1, 32'hffff_ffff));
    send(mk_cmd(sqb_pkg::CMD_END));
    send(mk_cmd(CmdUnused));
    send(mk_cmd(sqb_pkg::CMD_END));
    send(mk_cmd(sqb_pkg::CMD_BEGIN));
    send(mk_cmd(sqb_pkg::CMD_END));

    // fill every texture slot, the next new texture forces a flush
    send(mk_cmd(sqb_pkg::CMD_BEGIN));
    for (int i = 0; i < 33; i++) send(mk_draw(1'b1, 32'h1000 + 32'(i)));
    send(mk_draw(1'b1, 32'h1000 + 32'd32));
    send(mk_cmd(sqb_pkg::CMD_END));

    // random batches with noise
    for (int b = 0; b < 11; b++) begin
      if (b == 8) quiet = 1'b1;
      if ($urandom_range(0, 4) == 0) send(mk_cmd(CmdUnused));
      if ($urandom_range(0, 5) != 0) send(mk_cmd(sqb_pkg::CMD_BEGIN));
      repeat ($urandom_range(3, 12)) pick_draw();
      if ($urandom_range(0, 5) != 0) send(mk_cmd(sqb_pkg::CMD_END));
    end
    in_valid_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("sprite_quad_batch_setup_test passed");
    end else begin
      $display("sprite_quad_batch_setup_test failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== sprite_quad_batch_setup.f =====
hdl/sqb_pkg.sv
hdl/sqb_ram.sv
hdl/sqb_ctrl.sv
hdl/sqb_dp.sv
hdl/sprite_quad_batch_setup.sv
test/sprite_quad_batch_setup_check.sv
test/sprite_quad_batch_setup_test.sv
